@@ rtl/core/bvdr_pkg.sv @@
// Package: shared types and codes for the bias voltage DAC ramp controller.
`timescale 1ns / 1ps

package bvdr_pkg;

    localparam int MV_W     = 16;
    localparam int CODE_W   = 12;
    localparam int CMD_W    = 2;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd3;

    // Sample request codes
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_STAB   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COARSE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FINE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MV       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_APPROACH_MV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEPUP_MV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEPUP_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSHOOT_MV = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DAC_MAX      = 3'd6;

    // Ramp-down code step
    localparam logic [4:0] DOWN_STEP = 5'd20;

    typedef struct packed {
        logic [MV_W-1:0]   min_voltage_mv;
        logic [CODE_W-1:0] min_voltage_dac_code;
        logic [CODE_W-1:0] approach_mv;
        logic [MV_W-1:0]   stepup_voltage_mv;
        logic [CODE_W-1:0] stepup_dac_code;
        logic [CODE_W-1:0] overshoot_mv;
        logic [CODE_W-1:0] dac_max_code;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [MV_W-1:0]   target_mv;
        logic [MV_W-1:0]   sample_mv;
        logic [CODE_W-1:0] forced_code;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] dac_code;
        logic              ldo_on;
        logic              stepup_on;
        logic              quench_on;
        logic [REQ_W-1:0]  sample_request;
        logic              done_res;
        logic [MV_W-1:0]   actual_mv;
    } res_t;

endpackage

@@ rtl/core/bvdr_if.sv @@
// Interfaces: command beat channel and result beat channel.
`timescale 1ns / 1ps

interface bvdr_item_if;
    import bvdr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [MV_W-1:0]   target_mv;
    logic [MV_W-1:0]   sample_mv;
    logic [CODE_W-1:0] forced_code;

    modport source (output valid, output cmd, output target_mv, output sample_mv,
                    output forced_code, input ready);
    modport sink (input valid, input cmd, input target_mv, input sample_mv,
                  input forced_code, output ready);
endinterface

interface bvdr_res_if;
    import bvdr_pkg::*;

    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] dac_code;
    logic              ldo_on;
    logic              stepup_on;
    logic              quench_on;
    logic [REQ_W-1:0]  sample_request;
    logic              done_res;
    logic [MV_W-1:0]   actual_mv;

    modport source (output valid, output dac_code, output ldo_on, output stepup_on,
                    output quench_on, output sample_request, output done_res,
                    output actual_mv, input ready);
    modport sink (input valid, input dac_code, input ldo_on, input stepup_on,
                  input quench_on, input sample_request, input done_res,
                  input actual_mv, output ready);
endinterface

@@ rtl/core/bvdr_cfg.sv @@
// Configuration register file with reset defaults.
`timescale 1ns / 1ps

module bvdr_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bvdr_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [bvdr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output bvdr_pkg::cfg_t                     cfg
);
    import bvdr_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_voltage_mv       <= 16'd3000;
            cfg_reg.min_voltage_dac_code <= 12'd4095;
            cfg_reg.approach_mv          <= 12'd100;
            cfg_reg.stepup_voltage_mv    <= 16'd15000;
            cfg_reg.stepup_dac_code      <= 12'd2000;
            cfg_reg.overshoot_mv         <= 12'd50;
            cfg_reg.dac_max_code         <= 12'd4095;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_MIN_MV:       cfg_reg.min_voltage_mv       <= cfg_wdata;
                REG_MIN_CODE:     cfg_reg.min_voltage_dac_code <= cfg_wdata[CODE_W-1:0];
                REG_APPROACH_MV:  cfg_reg.approach_mv          <= cfg_wdata[CODE_W-1:0];
                REG_STEPUP_MV:    cfg_reg.stepup_voltage_mv    <= cfg_wdata;
                REG_STEPUP_CODE:  cfg_reg.stepup_dac_code      <= cfg_wdata[CODE_W-1:0];
                REG_OVERSHOOT_MV: cfg_reg.overshoot_mv         <= cfg_wdata[CODE_W-1:0];
                REG_DAC_MAX:      cfg_reg.dac_max_code         <= cfg_wdata[CODE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/bvdr_core.sv @@
// Controller core: input register, ramp state update and result register.
`timescale 1ns / 1ps

module bvdr_core #(
    parameter int DAC_BITS = 12
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bvdr_pkg::cfg_t cfg,
    bvdr_item_if.sink      item,
    bvdr_res_if.source     res
);
    import bvdr_pkg::*;

    localparam int MASK_BITS = (DAC_BITS < CODE_W) ? DAC_BITS : CODE_W;
    localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((32'd1 << MASK_BITS) - 32'd1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DOWN  = 2'd1,
        PH_UP    = 2'd2,
        PH_FORCE = 2'd3
    } phase_t;

    function automatic logic [CODE_W-1:0] code_dec(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] d;
        d = (c != '0) ? (c - 1'b1) : c;
        return d & CODE_MASK;
    endfunction

    function automatic logic [CODE_W-1:0] code_inc(input logic [CODE_W-1:0] c,
                                                   input logic [CODE_W-1:0] cmax);
        logic [CODE_W:0] s;
        s = {1'b0, c} + (CODE_W+1)'(DOWN_STEP);
        if (s > {1'b0, cmax})
            s = {1'b0, cmax};
        return s[CODE_W-1:0] & CODE_MASK;
    endfunction

    // target minus measured below approach, as a signed difference
    function automatic logic near_target(input logic [MV_W-1:0]   tgt,
                                         input logic [MV_W-1:0]   meas,
                                         input logic [CODE_W-1:0] app);
        logic signed [MV_W+1:0] d;
        d = $signed({2'b00, tgt}) - $signed({2'b00, meas});
        return d < $signed({{(MV_W+2-CODE_W){1'b0}}, app});
    endfunction

    // input stage
    item_t  in_reg;
    logic   in_vld_reg;
    logic   adv;

    // ramp state
    phase_t            phase_reg, phase_next;
    logic              ldo_reg, ldo_next;
    logic              stepup_reg, stepup_next;
    logic              quench_reg, quench_next;
    logic              fine_reg, fine_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [MV_W-1:0]   pend_reg, pend_next;
    logic [MV_W-1:0]   setv_reg, setv_next;
    logic [MV_W-1:0]   lastv_reg, lastv_next;
    logic [MV_W-1:0]   reach_reg, reach_next;

    // result stage
    res_t res_reg, res_next;
    logic out_vld_reg;

    logic [MV_W-1:0]   tgt;
    logic [CODE_W+1:0] app4;
    logic [MV_W:0]     sum;
    logic              start_up;
    logic [MV_W-1:0]   up_meas;

    assign adv        = in_vld_reg && (!out_vld_reg || res.ready);
    assign item.ready = !in_vld_reg || adv;

    always_comb
    begin
        phase_next  = phase_reg;
        ldo_next    = ldo_reg;
        stepup_next = stepup_reg;
        quench_next = quench_reg;
        fine_next   = fine_reg;
        code_next   = code_reg;
        pend_next   = pend_reg;
        setv_next   = setv_reg;
        lastv_next  = lastv_reg;
        reach_next  = reach_reg;
        res_next    = '0;
        start_up    = 1'b0;
        up_meas     = lastv_reg;
        tgt         = in_reg.target_mv;
        app4        = {cfg.approach_mv, 2'b00};
        sum         = {1'b0, in_reg.sample_mv} + (MV_W+1)'(cfg.overshoot_mv);

        unique case (in_reg.cmd)
            CMD_SET:
            begin
                if (phase_reg == PH_DOWN)
                    quench_next = 1'b0;
                phase_next = PH_IDLE;
                if (!ldo_reg)
                begin
                    quench_next = 1'b0;
                    lastv_next  = cfg.min_voltage_mv - 1'b1;
                    setv_next   = cfg.min_voltage_mv - 1'b1;
                    code_next   = cfg.min_voltage_dac_code & CODE_MASK;
                    ldo_next    = 1'b1;
                end
                if (in_reg.target_mv < cfg.min_voltage_mv)
                    tgt = cfg.min_voltage_mv;
                pend_next = tgt;
                if (setv_next == tgt)
                begin
                    res_next.done_res  = 1'b1;
                    res_next.actual_mv = lastv_next;
                end
                else if (setv_next > tgt)
                begin
                    if (setv_next >= cfg.stepup_voltage_mv && tgt < cfg.stepup_voltage_mv)
                        stepup_next = 1'b0;
                    if ({1'b0, tgt} > ({1'b0, cfg.min_voltage_mv} + (MV_W+1)'(app4)))
                        reach_next = tgt - MV_W'(app4);
                    else
                        reach_next = cfg.min_voltage_mv;
                    quench_next = 1'b1;
                    code_next   = code_inc(code_next, cfg.dac_max_code);
                    phase_next  = PH_DOWN;
                end
                else
                begin
                    start_up = 1'b1;
                    up_meas  = lastv_next;
                end
            end
            CMD_SAMPLE:
            begin
                unique case (phase_reg)
                    PH_DOWN:
                    begin
                        if (in_reg.sample_mv > reach_reg && code_reg != cfg.dac_max_code)
                            code_next = code_inc(code_reg, cfg.dac_max_code);
                        else
                        begin
                            quench_next = 1'b0;
                            start_up    = 1'b1;
                            up_meas     = in_reg.sample_mv;
                        end
                    end
                    PH_UP:
                    begin
                        if ($signed({2'b00, in_reg.sample_mv}) <
                            ($signed({2'b00, pend_reg})
                             - $signed({{(MV_W+2-CODE_W){1'b0}}, cfg.overshoot_mv}))
                            && code_reg != '0)
                        begin
                            if (!fine_reg && near_target(pend_reg, in_reg.sample_mv,
                                                         cfg.approach_mv))
                                fine_next = 1'b1;
                            code_next = code_dec(code_reg);
                        end
                        else
                        begin
                            setv_next          = pend_reg;
                            lastv_next         = sum[MV_W] ? '1 : sum[MV_W-1:0];
                            phase_next         = PH_IDLE;
                            res_next.done_res  = 1'b1;
                            res_next.actual_mv = lastv_next;
                        end
                    end
                    PH_FORCE:
                    begin
                        setv_next          = in_reg.sample_mv;
                        lastv_next         = in_reg.sample_mv;
                        phase_next         = PH_IDLE;
                        res_next.done_res  = 1'b1;
                        res_next.actual_mv = in_reg.sample_mv;
                    end
                    default: ;
                endcase
            end
            CMD_FORCE:
            begin
                if (phase_reg == PH_DOWN)
                    quench_next = 1'b0;
                if (in_reg.forced_code < cfg.stepup_dac_code && !stepup_reg)
                    stepup_next = 1'b1;
                else if (in_reg.forced_code > cfg.stepup_dac_code && stepup_reg)
                    stepup_next = 1'b0;
                code_next  = in_reg.forced_code & CODE_MASK;
                phase_next = PH_FORCE;
            end
            CMD_DISABLE:
            begin
                phase_next  = PH_IDLE;
                ldo_next    = 1'b0;
                stepup_next = 1'b0;
                quench_next = 1'b1;
            end
            default: ;
        endcase

        // start of the ramp up, shared by set-target and end of ramp down
        if (start_up)
        begin
            if (setv_next < cfg.stepup_voltage_mv && pend_next >= cfg.stepup_voltage_mv)
                stepup_next = 1'b1;
            fine_next  = near_target(pend_next, up_meas, cfg.approach_mv);
            code_next  = code_dec(code_next);
            phase_next = PH_UP;
        end

        res_next.dac_code  = code_next;
        res_next.ldo_on    = ldo_next;
        res_next.stepup_on = stepup_next;
        res_next.quench_on = quench_next;
        unique case (phase_next)
            PH_DOWN:  res_next.sample_request = REQ_STAB;
            PH_UP:    res_next.sample_request = fine_next ? REQ_FINE : REQ_COARSE;
            PH_FORCE: res_next.sample_request = REQ_FINE;
            default:  res_next.sample_request = REQ_NONE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_reg.cmd         <= item.cmd;
            in_reg.target_mv   <= item.target_mv;
            in_reg.sample_mv   <= item.sample_mv;
            in_reg.forced_code <= item.forced_code;
        end
        if (adv)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            phase_reg   <= PH_IDLE;
            ldo_reg     <= 1'b0;
            stepup_reg  <= 1'b0;
            quench_reg  <= 1'b0;
            fine_reg    <= 1'b0;
            code_reg    <= '0;
            pend_reg    <= '0;
            setv_reg    <= '0;
            lastv_reg   <= '0;
            reach_reg   <= '0;
        end
        else
        begin
            if (item.ready)
                in_vld_reg <= item.valid;
            if (adv)
                out_vld_reg <= 1'b1;
            else if (res.ready)
                out_vld_reg <= 1'b0;
            if (adv)
            begin
                phase_reg  <= phase_next;
                ldo_reg    <= ldo_next;
                stepup_reg <= stepup_next;
                quench_reg <= quench_next;
                fine_reg   <= fine_next;
                code_reg   <= code_next;
                pend_reg   <= pend_next;
                setv_reg   <= setv_next;
                lastv_reg  <= lastv_next;
                reach_reg  <= reach_next;
            end
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.dac_code       = res_reg.dac_code;
    assign res.ldo_on         = res_reg.ldo_on;
    assign res.stepup_on      = res_reg.stepup_on;
    assign res.quench_on      = res_reg.quench_on;
    assign res.sample_request = res_reg.sample_request;
    assign res.done_res       = res_reg.done_res;
    assign res.actual_mv      = res_reg.actual_mv;

    // ramp down always runs with the discharge path on
    a_down_quench: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DOWN |-> quench_reg)
        else $error("ramp down without quench");

    // a ramp up is only entered with the regulator on
    a_up_ldo: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_UP |-> ldo_reg)
        else $error("ramp up with regulator off");

    // voltage field is zero unless the beat finishes an operation
    a_done_mv: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res_reg.done_res |-> res_reg.actual_mv == '0)
        else $error("voltage reported without done");

    // a processed beat always lands in the result register
    a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> out_vld_reg)
        else $error("processed beat lost");

endmodule

@@ rtl/core/bias_voltage_dac_ramp_controller_unit.sv @@
// Top level: bias voltage DAC ramp controller with config port and beat channels.
// Pipeline: accepted command beats go to the input register, results to the result register.
// Throughput: one command beat per cycle while the result channel is not stalled; the
// single-pass state update sits between the input register and the result register.
// Reset: rst_n clears regulator, step-up and quench enables, DAC code and ramp
// state; configuration registers return to their defaults.
`timescale 1ns / 1ps

module bias_voltage_dac_ramp_controller_unit #(
    parameter int DAC_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bvdr_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [bvdr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    bvdr_item_if.sink                       item,
    bvdr_res_if.source                      result
);
    import bvdr_pkg::*;

    cfg_t cfg;

    bvdr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bvdr_core #(
        .DAC_BITS (DAC_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .item  (item),
        .res   (result)
    );

endmodule

@@ tb/bias_voltage_dac_ramp_controller_unit_tb.sv @@
// Self-checking testbench for the bias voltage DAC ramp controller: random beats, predicted results.
`timescale 1ns / 1ps

module bias_voltage_dac_ramp_controller_unit_tb;
    import bvdr_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int RESET_CYCLES     = 11;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 75;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 6;
    localparam int MV_MAX           = 65535;

    typedef enum logic [1:0] {RAMP_IDLE, RAMP_DOWN, RAMP_UP, RAMP_FORCE} ramp_phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bvdr_item_if item_ch ();
    bvdr_res_if  res_ch ();

    bias_voltage_dac_ramp_controller_unit #(
        .DAC_BITS (CODE_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (res_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // register copy
    logic [MV_W-1:0]   cfg_min_mv;
    logic [CODE_W-1:0] cfg_min_code;
    logic [CODE_W-1:0] cfg_approach;
    logic [MV_W-1:0]   cfg_stepup_mv;
    logic [CODE_W-1:0] cfg_stepup_code;
    logic [CODE_W-1:0] cfg_overshoot;
    logic [CODE_W-1:0] cfg_dac_max;

    // ramp state copy
    ramp_phase_t       rp_phase;
    logic              rp_ldo;
    logic              rp_stepup;
    logic              rp_quench;
    logic              rp_fine;
    logic [CODE_W-1:0] rp_code;
    logic [MV_W-1:0]   rp_target;
    logic [MV_W-1:0]   rp_set_mv;
    logic [MV_W-1:0]   rp_last_mv;
    logic [MV_W-1:0]   rp_reach_mv;
    logic              rp_done;
    logic [MV_W-1:0]   rp_done_mv;

    item_t pending_beats[$];
    res_t  expected_results[$];

    int errors      = 0;
    int cycle_count = 0;
    int result_seen = 0;
    bit item_taken  = 1'b0;
    bit idling      = 1'b1;
    bit hold_go     = 1'b0;
    bit holding     = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("beat %0d %s: got %0d, want %0d", result_seen, name,
                                      got, want));
    endtask

    function automatic void ramp_up_step(input logic [MV_W-1:0] meas);
        int diff;
        diff = int'(rp_target) - int'(meas);
        if (!rp_fine && diff < int'(cfg_approach))
            rp_fine = 1'b1;
        if (rp_code != '0)
            rp_code = rp_code - 1'b1;
        rp_phase = RAMP_UP;
    endfunction

    function automatic void ramp_up_start(input logic [MV_W-1:0] meas);
        if (rp_set_mv < cfg_stepup_mv && rp_target >= cfg_stepup_mv)
            rp_stepup = 1'b1;
        rp_fine = 1'b0;
        ramp_up_step(meas);
    endfunction

    function automatic void ramp_down_step();
        int c;
        c = int'(rp_code) + int'(DOWN_STEP);
        if (c > int'(cfg_dac_max))
            c = int'(cfg_dac_max);
        rp_code = CODE_W'(c);
    endfunction

    function automatic void ramp_finish(input logic [MV_W-1:0] mv);
        rp_phase   = RAMP_IDLE;
        rp_done    = 1'b1;
        rp_done_mv = mv;
    endfunction

    function automatic void abandon_op();
        if (rp_phase == RAMP_DOWN)
            rp_quench = 1'b0;
        rp_phase = RAMP_IDLE;
    endfunction

    function automatic res_t predict_beat(input item_t it);
        res_t            r;
        logic [MV_W-1:0] tgt;
        int              lim;
        int              a;
        rp_done    = 1'b0;
        rp_done_mv = '0;
        case (it.cmd)
            CMD_SET:
            begin
                abandon_op();
                if (!rp_ldo)
                begin
                    rp_quench  = 1'b0;
                    rp_last_mv = cfg_min_mv - 1'b1;
                    rp_set_mv  = rp_last_mv;
                    rp_code    = cfg_min_code;
                    rp_ldo     = 1'b1;
                end
                tgt = (it.target_mv < cfg_min_mv) ? cfg_min_mv : it.target_mv;
                rp_target = tgt;
                if (rp_set_mv == tgt)
                    ramp_finish(rp_last_mv);
                else if (rp_set_mv > tgt)
                begin
                    if (rp_set_mv >= cfg_stepup_mv && tgt < cfg_stepup_mv)
                        rp_stepup = 1'b0;
                    lim = int'(cfg_min_mv) + 4 * int'(cfg_approach);
                    if (int'(tgt) > lim)
                        rp_reach_mv = MV_W'(int'(tgt) - 4 * int'(cfg_approach));
                    else
                        rp_reach_mv = cfg_min_mv;
                    rp_quench = 1'b1;
                    ramp_down_step();
                    rp_phase = RAMP_DOWN;
                end
                else
                    ramp_up_start(rp_last_mv);
            end
            CMD_SAMPLE:
            begin
                case (rp_phase)
                    RAMP_DOWN:
                    begin
                        if (it.sample_mv > rp_reach_mv && rp_code != cfg_dac_max)
                            ramp_down_step();
                        else
                        begin
                            rp_quench = 1'b0;
                            ramp_up_start(it.sample_mv);
                        end
                    end
                    RAMP_UP:
                    begin
                        if (int'(it.sample_mv) < int'(rp_target) - int'(cfg_overshoot)
                            && rp_code != '0)
                            ramp_up_step(it.sample_mv);
                        else
                        begin
                            a = int'(it.sample_mv) + int'(cfg_overshoot);
                            if (a > MV_MAX)
                                a = MV_MAX;
                            rp_set_mv  = rp_target;
                            rp_last_mv = MV_W'(a);
                            ramp_finish(MV_W'(a));
                        end
                    end
                    RAMP_FORCE:
                    begin
                        rp_last_mv = it.sample_mv;
                        rp_set_mv  = it.sample_mv;
                        ramp_finish(it.sample_mv);
                    end
                    default: ;
                endcase
            end
            CMD_FORCE:
            begin
                abandon_op();
                if (it.forced_code < cfg_stepup_code && !rp_stepup)
                    rp_stepup = 1'b1;
                else if (it.forced_code > cfg_stepup_code && rp_stepup)
                    rp_stepup = 1'b0;
                rp_code  = it.forced_code;
                rp_phase = RAMP_FORCE;
            end
            CMD_DISABLE:
            begin
                rp_phase  = RAMP_IDLE;
                rp_ldo    = 1'b0;
                rp_stepup = 1'b0;
                rp_quench = 1'b1;
            end
            default: ;
        endcase

        case (rp_phase)
            RAMP_DOWN:  r.sample_request = REQ_STAB;
            RAMP_UP:    r.sample_request = rp_fine ? REQ_FINE : REQ_COARSE;
            RAMP_FORCE: r.sample_request = REQ_FINE;
            default:    r.sample_request = REQ_NONE;
        endcase
        r.dac_code  = rp_code;
        r.ldo_on    = rp_ldo;
        r.stepup_on = rp_stepup;
        r.quench_on = rp_quench;
        r.done_res  = rp_done;
        r.actual_mv = rp_done_mv;
        return r;
    endfunction

    function automatic int clamp_mv(input int v);
        if (v < 0)
            return 0;
        if (v > MV_MAX)
            return MV_MAX;
        return v;
    endfunction

    function automatic item_t random_beat();
        item_t b;
        b.cmd         = CMD_W'($urandom_range(0, 3));
        b.target_mv   = MV_W'($urandom_range(0, MV_MAX));
        b.sample_mv   = MV_W'($urandom_range(0, MV_MAX));
        b.forced_code = CODE_W'($urandom_range(0, 4095));
        return b;
    endfunction

    task automatic queue_beat(input logic [CMD_W-1:0] cmd, input int tgt, input int smp,
                              input int frc);
        item_t b;
        b.cmd         = cmd;
        b.target_mv   = MV_W'(tgt);
        b.sample_mv   = MV_W'(smp);
        b.forced_code = CODE_W'(frc);
        pending_beats.push_back(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= d;
        case (idx)
            REG_MIN_MV:       cfg_min_mv      = d;
            REG_MIN_CODE:     cfg_min_code    = d[CODE_W-1:0];
            REG_APPROACH_MV:  cfg_approach    = d[CODE_W-1:0];
            REG_STEPUP_MV:    cfg_stepup_mv   = d;
            REG_STEPUP_CODE:  cfg_stepup_code = d[CODE_W-1:0];
            REG_OVERSHOOT_MV: cfg_overshoot   = d[CODE_W-1:0];
            REG_DAC_MAX:      cfg_dac_max     = d[CODE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input int min_mv, input int min_code, input int approach,
                              input int stepup_mv, input int stepup_code, input int overshoot,
                              input int dac_max);
        write_reg(REG_MIN_MV, min_mv);
        write_reg(REG_MIN_CODE, min_code);
        write_reg(REG_APPROACH_MV, approach);
        write_reg(REG_STEPUP_MV, stepup_mv);
        write_reg(REG_STEPUP_CODE, stepup_code);
        write_reg(REG_OVERSHOOT_MV, overshoot);
        write_reg(REG_DAC_MAX, dac_max);
    endtask

    // mostly set-target beats followed by a falling then rising run of samples
    task automatic queue_traffic(input int n);
        item_t b;
        int    pick;
        int    tgt;
        int    hi;
        int    lo;
        int    k1;
        int    k2;
        int    top;
        while (pending_beats.size() < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 3) == 0)
                    tgt = $urandom_range(0, MV_MAX);
                else
                    tgt = clamp_mv(int'(cfg_min_mv) + $urandom_range(0, 20000));
                b = random_beat();
                b.cmd = CMD_SET;
                b.target_mv = MV_W'(tgt);
                pending_beats.push_back(b);
                if (tgt < int'(cfg_min_mv))
                    tgt = int'(cfg_min_mv);
                hi  = tgt + $urandom_range(0, 3000);
                lo  = tgt - 4 * int'(cfg_approach) - $urandom_range(0, 500);
                top = tgt + $urandom_range(0, 60);
                k1  = $urandom_range(0, 5);
                k2  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
                for (int i = 0; i < k1; i++)
                begin
                    b = random_beat();
                    b.cmd = CMD_SAMPLE;
                    b.sample_mv = MV_W'(clamp_mv(hi - (hi - lo) * i / k1));
                    pending_beats.push_back(b);
                end
                for (int j = 0; j < k2; j++)
                begin
                    b = random_beat();
                    b.cmd = CMD_SAMPLE;
                    b.sample_mv = MV_W'(clamp_mv(lo + (top - lo) * (j + 1) / k2));
                    pending_beats.push_back(b);
                end
            end
            else if (pick < 72)
            begin
                b = random_beat();
                b.cmd = CMD_FORCE;
                pending_beats.push_back(b);
                if ($urandom_range(0, 4) != 0)
                begin
                    b = random_beat();
                    b.cmd = CMD_SAMPLE;
                    pending_beats.push_back(b);
                end
            end
            else if (pick < 77)
            begin
                b = random_beat();
                b.cmd = CMD_DISABLE;
                pending_beats.push_back(b);
            end
            else
                pending_beats.push_back(random_beat());
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || item_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : drive_beats
        item_t b;
        if (!item_ch.valid || item_taken)
        begin
            item_taken = 1'b0;
            if (pending_beats.size() != 0 && !(idling && $urandom_range(0, 99) < 32))
            begin
                b = pending_beats.pop_front();
                item_ch.cmd         <= b.cmd;
                item_ch.target_mv   <= b.target_mv;
                item_ch.sample_mv   <= b.sample_mv;
                item_ch.forced_code <= b.forced_code;
                item_ch.valid       <= 1'b1;
            end
            else
                item_ch.valid <= 1'b0;
        end
        res_ch.ready <= !holding && !(idling && $urandom_range(0, 99) < 32);
    end

    always @(posedge clk)
    begin : watch_beats
        item_t b;
        res_t  want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result beat %0d with nothing expected",
                                              result_seen));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("dac_code", res_ch.dac_code, want.dac_code);
                    check_field("ldo_on", res_ch.ldo_on, want.ldo_on);
                    check_field("stepup_on", res_ch.stepup_on, want.stepup_on);
                    check_field("quench_on", res_ch.quench_on, want.quench_on);
                    check_field("sample_request", res_ch.sample_request, want.sample_request);
                    check_field("done_res", res_ch.done_res, want.done_res);
                    check_field("actual_mv", res_ch.actual_mv, want.actual_mv);
                end
                result_seen++;
            end
            if (item_ch.valid && item_ch.ready)
            begin
                b.cmd         = item_ch.cmd;
                b.target_mv   = item_ch.target_mv;
                b.sample_mv   = item_ch.sample_mv;
                b.forced_code = item_ch.forced_code;
                expected_results.push_back(predict_beat(b));
                item_taken = 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up onto its input
    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("bias_voltage_dac_ramp_controller_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin : run_test
        cfg_min_mv      = 16'd3000;
        cfg_min_code    = 12'd4095;
        cfg_approach    = 12'd100;
        cfg_stepup_mv   = 16'd15000;
        cfg_stepup_code = 12'd2000;
        cfg_overshoot   = 12'd50;
        cfg_dac_max     = 12'd4095;
        rp_phase        = RAMP_IDLE;
        rp_ldo          = 1'b0;
        rp_stepup       = 1'b0;
        rp_quench       = 1'b0;
        rp_fine         = 1'b0;
        rp_code         = '0;
        rp_target       = '0;
        rp_set_mv       = '0;
        rp_last_mv      = '0;
        rp_reach_mv     = '0;
        rp_done         = 1'b0;
        rp_done_mv      = '0;

        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_wdata           = '0;
        item_ch.valid       = 1'b0;
        item_ch.cmd         = CMD_SET;
        item_ch.target_mv   = '0;
        item_ch.sample_mv   = '0;
        item_ch.forced_code = '0;
        res_ch.ready        = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings
        queue_beat(CMD_SAMPLE, 0, 1234, 0);      // idle sample, ignored
        queue_beat(CMD_SET, 0, 0, 0);            // clamp to minimum, power up
        queue_beat(CMD_SAMPLE, 0, 2900, 0);
        queue_beat(CMD_SAMPLE, 0, 2960, 0);
        queue_beat(CMD_SAMPLE, 0, 2960, 0);
        queue_beat(CMD_SET, 3000, 0, 0);         // same target
        queue_beat(CMD_SET, 65535, 0, 0);        // step-up on
        queue_beat(CMD_SAMPLE, 0, 0, 0);
        queue_beat(CMD_SAMPLE, 0, 65535, 0);     // overshoot saturates
        queue_beat(CMD_SET, 5000, 0, 0);         // ramp down, quench
        queue_beat(CMD_SAMPLE, 0, 65535, 0);
        queue_beat(CMD_SAMPLE, 0, 0, 0);
        queue_beat(CMD_SAMPLE, 0, 4990, 0);
        queue_beat(CMD_SET, 4000, 0, 0);
        queue_beat(CMD_SET, 6000, 0, 0);         // ramp down abandoned
        queue_beat(CMD_FORCE, 0, 0, 0);
        queue_beat(CMD_SAMPLE, 0, 1234, 0);
        queue_beat(CMD_FORCE, 0, 0, 4095);
        queue_beat(CMD_FORCE, 0, 0, 2000);
        queue_beat(CMD_SAMPLE, 0, 0, 0);
        queue_beat(CMD_SET, 9000, 0, 0);
        queue_beat(CMD_DISABLE, 0, 0, 0);
        queue_beat(CMD_SAMPLE, 0, 777, 0);
        queue_beat(CMD_SET, 20000, 0, 0);
        queue_beat(CMD_DISABLE, 65535, 65535, 4095);
        wait_idle();

        for (int p = 0; p < 7; p++)
        begin
            idling = 1'b1;
            case (p)
                0: set_config(0, 0, 0, 0, 0, 0, 0);
                1: set_config(65535, 4095, 4095, 65535, 4095, 4095, 4095);
                2:
                begin
                    set_config(3000, 4095, 100, 15000, 2000, 50, 4095);
                    idling = 1'b0;
                end
                5: set_config($urandom_range(0, MV_MAX), $urandom_range(0, MV_MAX),
                              $urandom_range(0, MV_MAX), $urandom_range(0, MV_MAX),
                              $urandom_range(0, MV_MAX), $urandom_range(0, MV_MAX),
                              $urandom_range(0, MV_MAX));
                6: set_config($urandom_range(1000, 5000), $urandom_range(0, 40),
                              $urandom_range(0, 150), $urandom_range(0, MV_MAX),
                              $urandom_range(0, 4095), $urandom_range(0, 100),
                              $urandom_range(0, 60));
                default: set_config($urandom_range(0, 6000), $urandom_range(0, 4095),
                                    $urandom_range(0, 400), $urandom_range(3000, 30000),
                                    $urandom_range(0, 4095), $urandom_range(0, 200),
                                    $urandom_range(0, 4095));
            endcase
            queue_traffic(RANDOM_PER_PHASE);
            if (p == 4)
                hold_go = 1'b1;
            wait_idle();
        end

        if (errors == 0)
            $display("bias_voltage_dac_ramp_controller_unit_tb: done, clean");
        else
            $display("bias_voltage_dac_ramp_controller_unit_tb: done, errors");
        $finish;
    end

endmodule
